### hdl/bfsk_pkg.sv
// ----------------------------------------------------------------------------
// Bloom filter package
// Shared types and constants for the string-key Bloom filter engine.
// ----------------------------------------------------------------------------
`default_nettype none

package bfsk_pkg;

  localparam int unsigned STORE_BYTES_DEF = 8192;
  localparam int unsigned HASH_FUNCS_DEF = 9;
  localparam int unsigned MAX_KEY_LEN_DEF = 255;

  localparam logic [13:0] BYTES_RESET = 14'd8192;
  localparam logic [3:0] HCOUNT_RESET = 4'd7;

  localparam logic [0:0] REG_BYTES = 1'b0;
  localparam logic [0:0] REG_HCOUNT = 1'b1;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [31:0] JS_INIT = 32'd1315423911;
  localparam logic [31:0] DJB_INIT = 32'd5381;
  localparam logic [31:0] AP_INIT = 32'hAAAAAAAA;
  localparam logic [31:0] RS_MULT_INIT = 32'd63689;
  localparam logic [31:0] RS_MULT_STEP = 32'd378551;

  typedef struct packed {
    logic       opcode;
    logic [7:0] key_byte;
    logic [7:0] key_length;
    logic       last_byte;
  } bfsk_in_t;

  typedef struct packed {
    logic        found;
    logic        was_insert;
    logic [31:0] keys_inserted;
  } bfsk_out_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_DIV,
    BK_READ,
    BK_WAIT,
    BK_CHECK,
    BK_DONE
  } bk_state_t;

  function automatic logic [31:0] asr32(input logic [31:0] x, input int unsigned n);
    asr32 = 32'($signed(x) >>> n);
  endfunction

endpackage

`default_nettype wire

### hdl/bfsk_front.sv
// ----------------------------------------------------------------------------
// Bloom filter hash front end
// Absorbs one key byte per accepted item into nine string hashes and, on the
// last byte, pushes the finished key (hashes and opcode) toward the back end.
// The two RS multiplications are split: the accumulator product is formed in
// the take step and the multiplier product in the phase step.
// ----------------------------------------------------------------------------
`default_nettype none

module bfsk_front
  import bfsk_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             take,
  input  wire bfsk_in_t         item,
  output logic                  busy,
  output logic                  push,
  output logic [9*32-1:0]       hashes,
  output logic                  push_op,
  input  wire logic             q_full
);

  logic [31:0] h [9];
  logic [31:0] rs_mult;
  logic [7:0]  pos;
  logic        phase;
  logic [31:0] c_reg;
  logic        last_reg;
  logic        op_reg;
  logic        hold;

  logic [31:0] c;
  logic [31:0] h7s;
  logic [31:0] n [9];
  logic [31:0] t2, t3, p2, p3;

  assign c = {{24{item.key_byte[7]}}, item.key_byte};

  always_comb begin
    h7s = (pos == 8'd0) ? {24'd0, item.key_length} : h[7];
    n[0] = h[0];
    n[1] = h[1] ^ ((h[1] << 5) + c + asr32(h[1], 2));
    p2 = (h[2] << 4) + c;
    t2 = p2 & 32'hF0000000;
    n[2] = (t2 != 32'd0) ? ((p2 ^ asr32(t2, 24)) & 32'h0FFFFFFF) : p2;
    p3 = (h[3] << 4) + c;
    t3 = p3 & 32'hF0000000;
    n[3] = ((t3 != 32'd0) ? (p3 ^ asr32(t3, 24)) : p3) & ~t3;
    n[4] = (h[4] << 7) + (h[4] << 1) + h[4] + c;
    n[5] = c + (h[5] << 6) + (h[5] << 16) - h[5];
    n[6] = (h[6] << 5) + h[6] + c;
    n[7] = ((h7s << 5) ^ asr32(h7s, 27)) ^ c;
    if (pos[0] == 1'b0) begin
      n[8] = h[8] ^ ((h[8] << 7) ^ (c * asr32(h[8], 3)));
    end else begin
      n[8] = h[8] ^ ~(((h[8] << 11) + c) ^ asr32(h[8], 5));
    end
  end

  // Phase 1 finishes the RS update; hold waits for queue room on a last byte.
  assign busy = phase | hold;
  assign push = hold & ~q_full;
  assign push_op = op_reg;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= 1'b0;
      hold <= 1'b0;
      pos <= 8'd0;
      rs_mult <= RS_MULT_INIT;
      h[0] <= 32'd0; h[1] <= JS_INIT; h[2] <= 32'd0; h[3] <= 32'd0;
      h[4] <= 32'd0; h[5] <= 32'd0; h[6] <= DJB_INIT; h[7] <= 32'd0;
      h[8] <= AP_INIT;
    end else if (take) begin
      for (int i = 1; i < 9; i++) h[i] <= n[i];
      h[0] <= h[0] * rs_mult;
      c_reg <= c;
      last_reg <= item.last_byte;
      op_reg <= item.opcode;
      pos <= pos + 8'd1;
      phase <= 1'b1;
    end else if (phase) begin
      h[0] <= h[0] + c_reg;
      rs_mult <= rs_mult * RS_MULT_STEP;
      phase <= 1'b0;
      hold <= last_reg;
    end else if (push) begin
      hold <= 1'b0;
      pos <= 8'd0;
      rs_mult <= RS_MULT_INIT;
      h[0] <= 32'd0; h[1] <= JS_INIT; h[2] <= 32'd0; h[3] <= 32'd0;
      h[4] <= 32'd0; h[5] <= 32'd0; h[6] <= DJB_INIT; h[7] <= 32'd0;
      h[8] <= AP_INIT;
    end
  end

  always_comb begin
    for (int i = 0; i < 9; i++) hashes[i*32 +: 32] = h[i];
  end

endmodule

`default_nettype wire

### hdl/bfsk_queue.sv
// ----------------------------------------------------------------------------
// Bloom filter key queue
// Two-entry queue of finished keys between the hash front end and the probe
// back end.
// ----------------------------------------------------------------------------
`default_nettype none

module bfsk_queue
  import bfsk_pkg::*;
#(
  parameter int unsigned WIDTH = 289
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  output logic                  full,
  input  wire logic             pop,
  output logic                  nonempty,
  output logic [WIDTH-1:0]      rdata
);

  logic [WIDTH-1:0] mem [2];
  logic             wp, rp;
  logic [1:0]       cnt;

  assign full = (cnt == 2'd2);
  assign nonempty = (cnt != 2'd0);
  assign rdata = mem[rp];

  always_ff @(posedge clk) begin
    if (push) mem[wp] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
      cnt <= cnt + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

`default_nettype wire

### hdl/bfsk_back.sv
// ----------------------------------------------------------------------------
// Bloom filter probe back end
// Takes finished keys from the queue, reduces each hash magnitude modulo the
// probe range with a bit-serial divider, reads the store bits, checks them on
// query, sets them on insert, and runs a one-byte-a-cycle clear after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module bfsk_back
  import bfsk_pkg::*;
#(
  parameter int unsigned STORE_BYTES = STORE_BYTES_DEF,
  parameter int unsigned HASH_FUNCS = HASH_FUNCS_DEF,
  localparam int unsigned AW = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1,
  localparam int unsigned RW = AW + 4
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             q_nonempty,
  input  wire logic [9*32:0]    q_data,
  output logic                  q_pop,
  input  wire logic [13:0]      cfg_bytes,
  input  wire logic [3:0]       cfg_hcount,
  output logic                  clearing,
  output logic                  res_valid,
  output bfsk_out_t             res
);

  bk_state_t   state, state_next;
  logic [7:0]  mem [STORE_BYTES];
  logic [7:0]  rd;
  logic [AW:0] clr_addr;
  logic [3:0]  hi, kk;
  logic [31:0] dividend;
  logic [RW-1:0] rem, range;
  logic [5:0]  bitn;
  logic        found;
  logic [31:0] count;
  logic        op;
  logic [RW:0] trial;
  logic [AW-1:0] idx;
  logic [2:0]  bo;
  logic        div_done;

  always_comb begin
    logic [31:0] b;
    b = {18'd0, cfg_bytes};
    if (b == 32'd0) b = 32'd1;
    if (b > STORE_BYTES) b = STORE_BYTES;
    range = RW'(b) << 3;
  end

  assign op = q_data[9*32];
  assign trial = {rem, dividend[31]} - {1'b0, range};
  assign idx = AW'(rem >> 3);
  assign bo = rem[2:0];
  assign clearing = ~clr_addr[AW];
  assign div_done = (bitn == 6'd0);

  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE:  if (q_nonempty && !clearing) state_next = (kk == 4'd0) ? BK_DONE : BK_DIV;
      BK_DIV:   if (div_done) state_next = BK_READ;
      BK_READ:  state_next = BK_WAIT;
      BK_WAIT:  state_next = BK_CHECK;
      BK_CHECK: state_next = (hi + 4'd1 >= kk) ? BK_DONE : BK_DIV;
      BK_DONE:  state_next = BK_IDLE;
      default:  state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    q_pop = 1'b0;
    res_valid = 1'b0;
    unique case (state)
      BK_DONE: begin
        q_pop = 1'b1;
        res_valid = 1'b1;
      end
      default: ;
    endcase
  end

  // The reported count already includes the key that finishes now if it is an insert.
  assign res.found = op & found;
  assign res.was_insert = ~op;
  assign res.keys_inserted = (op == OP_INSERT && count != 32'hFFFFFFFF) ? count + 32'd1
                                                                          : count;

  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_addr[AW-1:0]] <= 8'd0;
    end else if (state == BK_CHECK && op == OP_INSERT) begin
      mem[idx] <= rd | (8'd1 << bo);
    end
    rd <= mem[idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
      clr_addr <= '0;
      count <= 32'd0;
      hi <= 4'd0;
      bitn <= 6'd0;
      found <= 1'b1;
    end else begin
      state <= state_next;
      if (clearing) begin
        clr_addr <= (clr_addr[AW-1:0] == AW'(STORE_BYTES - 1)) ? {1'b1, {AW{1'b0}}}
                                                               : clr_addr + 1'b1;
      end
      unique case (state)
        BK_IDLE: begin
          hi <= 4'd0;
          found <= 1'b1;
          kk <= (cfg_hcount > HASH_FUNCS) ? 4'(HASH_FUNCS) : cfg_hcount;
          dividend <= q_data[31] ? (32'd0 - q_data[31:0]) : q_data[31:0];
          rem <= '0;
          bitn <= 6'd32;
        end
        BK_DIV: begin
          if (!div_done) begin
            rem <= trial[RW] ? RW'({rem, dividend[31]}) : trial[RW-1:0];
            dividend <= dividend << 1;
            bitn <= bitn - 6'd1;
          end
        end
        BK_CHECK: begin
          if (op == OP_QUERY && rd[bo] == 1'b0) found <= 1'b0;
          hi <= hi + 4'd1;
          begin
            logic [31:0] nx;
            nx = q_data[(hi+4'd1)*32 +: 32];
            dividend <= nx[31] ? (32'd0 - nx) : nx;
          end
          rem <= '0;
          bitn <= 6'd32;
        end
        BK_DONE: begin
          if (op == OP_INSERT && count != 32'hFFFFFFFF) count <= count + 32'd1;
        end
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

### hdl/bloom_filter_string_keys_top.sv
// ----------------------------------------------------------------------------
// Bloom filter engine, string keys
// Byte-serial key hashing with Bloom filter insert and query.
// ----------------------------------------------------------------------------
// Each key byte passes through a take cycle and a phase cycle in the hash
// front end (busy is high for one cycle after an accepted start) because the
// RS hash uses two 32-bit multiplications in sequence. A last byte keeps busy
// high through a hold state while the finished key is written into a
// two-entry queue, and longer while that queue is full. For each hash the
// probe back end runs a bit-serial modulo, a store read, a wait state and a
// check that sets the store bit on an insert; it picks up the key in its idle
// state and raises the result in a done state. The result strobe lasts one
// cycle and cannot be stalled. After reset the store is cleared one byte a
// cycle while busy stays high.
`default_nettype none

module bloom_filter_string_keys_top
  import bfsk_pkg::*;
#(
  parameter int unsigned STORE_BYTES = STORE_BYTES_DEF,
  parameter int unsigned HASH_FUNCS = HASH_FUNCS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire bfsk_in_t    item,
  output logic             busy,
  output logic             result_valid,
  output bfsk_out_t        result,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [13:0] cfg_data
);

  logic [13:0]  cfg_bytes;
  logic [3:0]   cfg_hcount;
  logic         fe_busy, push, push_op, q_full, q_pop, q_ne, clearing;
  logic [9*32-1:0] hashes;
  logic [9*32:0]   q_rdata;
  logic         take;

  assign cfg_ready = 1'b1;
  assign busy = fe_busy | clearing;
  assign take = start & ~busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_bytes <= BYTES_RESET;
      cfg_hcount <= HCOUNT_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_BYTES:  cfg_bytes <= cfg_data;
        REG_HCOUNT: cfg_hcount <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  bfsk_front u_front (
    .clk(clk), .rst(rst), .take(take), .item(item), .busy(fe_busy),
    .push(push), .hashes(hashes), .push_op(push_op), .q_full(q_full)
  );

  bfsk_queue #(.WIDTH(9*32+1)) u_queue (
    .clk(clk), .rst(rst), .push(push), .wdata({push_op, hashes}), .full(q_full),
    .pop(q_pop), .nonempty(q_ne), .rdata(q_rdata)
  );

  bfsk_back #(.STORE_BYTES(STORE_BYTES), .HASH_FUNCS(HASH_FUNCS)) u_back (
    .clk(clk), .rst(rst), .q_nonempty(q_ne), .q_data(q_rdata), .q_pop(q_pop),
    .cfg_bytes(cfg_bytes), .cfg_hcount(cfg_hcount), .clearing(clearing),
    .res_valid(result_valid), .res(result)
  );

endmodule

`default_nettype wire

### hdl/bfsk_checker.sv
// ----------------------------------------------------------------------------
// Bloom filter port checker
// Watches the top-level ports for result, busy and strobe consistency.
// ----------------------------------------------------------------------------
`default_nettype none

module bfsk_checker
  import bfsk_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst,
  input wire logic      start,
  input wire logic      busy,
  input wire logic      result_valid,
  input wire bfsk_out_t result
);

  a_insert_not_found: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.was_insert |-> !result.found)
    else $error("insert reported found");

  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("busy not raised after transfer");

  a_strobe_single: assert property (@(posedge clk) disable iff (rst)
    result_valid |=> !result_valid)
    else $error("back-to-back result strobes");

  a_busy_in_reset: assert property (@(posedge clk)
    rst |=> busy)
    else $error("busy low right after reset");

endmodule

bind bloom_filter_string_keys_top bfsk_checker u_chk (
  .clk(clk), .rst(rst), .start(start), .busy(busy),
  .result_valid(result_valid), .result(result)
);

`default_nettype wire

### bench/bloom_filter_string_keys_top_test.sv
// ----------------------------------------------------------------------------
// Bloom filter engine testbench
// Sends byte-serial keys as inserts and queries under several store sizes and
// hash counts, checking each result strobe field by field, in order, against
// its predictor of the nine string hashes and store, or a typed row's result.
// ----------------------------------------------------------------------------
`default_nettype none

module bloom_filter_string_keys_top_test;
  import bfsk_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STORE_SZ = 8192;
  localparam int BANK_MAX = 64;
  localparam int KEY_MAX = 300;
  localparam int SETTLE = 500;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  bfsk_in_t    item = '0;
  logic        busy;
  logic        result_valid;
  bfsk_out_t   result;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [0:0]  cfg_index = REG_BYTES;
  logic [13:0] cfg_data = '0;

  bloom_filter_string_keys_top uut (
    .clk(clk), .rst(rst), .start(start), .item(item), .busy(busy),
    .result_valid(result_valid), .result(result), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  // Predictor state.
  logic [31:0] acc [9];
  logic [31:0] rs_mul;
  logic [7:0]  key_pos;
  logic [31:0] insert_total;
  logic [13:0] store_bytes;
  logic [3:0]  num_hashes;
  logic [7:0]  bit_mem [STORE_SZ];

  bfsk_out_t   pending_results [$];
  int          error_count = 0;
  int          bytes_sent = 0;
  int          keys_sent = 0;
  int          results_seen = 0;
  int          found_hits = 0;
  bit          idle_on = 1'b1;

  // Key bank of inserted keys, replayed later as queries.
  logic [7:0]  bank_bytes [BANK_MAX][16];
  int          bank_len [BANK_MAX];
  logic [7:0]  bank_dlen [BANK_MAX];
  int          bank_n = 0;
  logic [7:0]  key_buf [KEY_MAX];

  function automatic logic [31:0] sra32(input logic [31:0] x, input int n);
    logic signed [31:0] s;
    s = x;
    return s >>> n;
  endfunction

  function automatic void restart_hashes();
    acc[0] = 32'd0;
    acc[1] = 32'd1315423911;
    acc[2] = 32'd0;
    acc[3] = 32'd0;
    acc[4] = 32'd0;
    acc[5] = 32'd0;
    acc[6] = 32'd5381;
    acc[7] = 32'd0;
    acc[8] = 32'hAAAAAAAA;
    rs_mul = 32'd63689;
    key_pos = 8'd0;
  endfunction

  // Advances the hashes by one byte; returns 1 with a result at a key end.
  function automatic bit hash_and_probe(input bfsk_in_t it, output bfsk_out_t r);
    logic [31:0] c, t, h, mag, off, span, bytes;
    int k;
    bit hit;
    c = {{24{it.key_byte[7]}}, it.key_byte};
    r = '0;
    if (key_pos == 8'd0) acc[7] = {24'd0, it.key_length};
    acc[0] = acc[0] * rs_mul + c;
    rs_mul = rs_mul * 32'd378551;
    acc[1] = acc[1] ^ ((acc[1] << 5) + c + sra32(acc[1], 2));
    acc[2] = (acc[2] << 4) + c;
    t = acc[2] & 32'hF0000000;
    if (t != 0) acc[2] = (acc[2] ^ sra32(t, 24)) & 32'h0FFFFFFF;
    acc[3] = (acc[3] << 4) + c;
    t = acc[3] & 32'hF0000000;
    if (t != 0) acc[3] = acc[3] ^ sra32(t, 24);
    acc[3] = acc[3] & ~t;
    acc[4] = acc[4] * 32'd131 + c;
    acc[5] = c + (acc[5] << 6) + (acc[5] << 16) - acc[5];
    acc[6] = (acc[6] << 5) + acc[6] + c;
    acc[7] = ((acc[7] << 5) ^ sra32(acc[7], 27)) ^ c;
    if (!key_pos[0])
      acc[8] = acc[8] ^ ((acc[8] << 7) ^ (c * sra32(acc[8], 3)));
    else
      acc[8] = acc[8] ^ ~(((acc[8] << 11) + c) ^ sra32(acc[8], 5));
    key_pos = key_pos + 8'd1;
    if (!it.last_byte) return 1'b0;

    bytes = {18'd0, store_bytes};
    if (bytes == 0) bytes = 1;
    if (bytes > STORE_SZ) bytes = STORE_SZ;
    span = bytes * 8;
    k = (num_hashes > 9) ? 9 : num_hashes;
    hit = 1'b1;
    for (int i = 0; i < k; i++) begin
      h = acc[i];
      mag = h[31] ? (32'd0 - h) : h;
      off = mag % span;
      if (it.opcode == OP_INSERT)
        bit_mem[off >> 3] = bit_mem[off >> 3] | (8'd1 << off[2:0]);
      else if (bit_mem[off >> 3][off[2:0]] == 1'b0)
        hit = 1'b0;
    end
    if (it.opcode == OP_INSERT && insert_total != 32'hFFFFFFFF)
      insert_total = insert_total + 1;
    r.found = (it.opcode == OP_QUERY) && hit;
    r.was_insert = (it.opcode == OP_INSERT);
    r.keys_inserted = insert_total;
    restart_hashes();
    return 1'b1;
  endfunction

  task automatic report(input string field, input logic [31:0] got, input logic [31:0] want);
    $display("%0t: %s mismatch, got %0h want %0h", $realtime, field, got, want);
    error_count++;
  endtask

  always @(posedge clk) begin
    bfsk_out_t want;
    if (!rst && result_valid) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        report("unexpected result", result.keys_inserted, 32'd0);
      end else begin
        want = pending_results.pop_front();
        if (result.found !== want.found)
          report("found", {31'd0, result.found}, {31'd0, want.found});
        if (result.was_insert !== want.was_insert)
          report("was_insert", {31'd0, result.was_insert}, {31'd0, want.was_insert});
        if (result.keys_inserted !== want.keys_inserted)
          report("keys_inserted", result.keys_inserted, want.keys_inserted);
        if (want.found) found_hits++;
      end
    end
  end

  // One byte transfer; start stays high across back-to-back items unless a random idle gap drops it.
  task automatic send(input bfsk_in_t it, input bit typed, input bfsk_out_t typed_res);
    bfsk_out_t r;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    start <= 1'b1;
    item <= it;
    do @(posedge clk); while (busy);
    bytes_sent++;
    if (hash_and_probe(it, r)) begin
      keys_sent++;
      pending_results.push_back(typed ? typed_res : r);
    end
  endtask

  // Sends key_buf[0..n-1]; dlen rides on the first byte.
  task automatic send_key(input logic op, input int n, input logic [7:0] dlen);
    bfsk_in_t it;
    for (int i = 0; i < n; i++) begin
      it.opcode = (i == n - 1) ? op : logic'($urandom_range(0, 1));
      it.key_byte = key_buf[i];
      it.key_length = (i == 0) ? dlen : 8'($urandom);
      it.last_byte = (i == n - 1);
      send(it, 1'b0, '0);
    end
  endtask

  task automatic quiesce();
    int waited;
    waited = 0;
    start <= 1'b0;
    while (pending_results.size() != 0 && waited < 400000) begin
      @(posedge clk);
      waited++;
    end
    if (pending_results.size() != 0) begin
      $display("bloom_filter_string_keys_top_test: errors");
      $finish;
    end else begin
      repeat (SETTLE) @(posedge clk);
    end
  endtask

  // Leaves cfg_valid high; the caller drops it after the last write.
  task automatic write_reg(input logic [0:0] idx, input logic [13:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_BYTES) store_bytes = val;
    else num_hashes = val[3:0];
  endtask

  typedef struct {
    logic       op;
    logic [7:0] kb;
    logic [7:0] kl;
    logic       last;
    bit         typed;
    bfsk_out_t  res;
  } stim_row_t;

  stim_row_t directed_rows [12];

  initial begin
    // Short keys at the byte extremes; repeated keys must hit.
    directed_rows = '{
      '{OP_QUERY,  8'h00, 8'd1,   1'b1, 1'b1, '{1'b0, 1'b0, 32'd0}},
      '{OP_INSERT, 8'hFF, 8'd255, 1'b1, 1'b1, '{1'b0, 1'b1, 32'd1}},
      '{OP_QUERY,  8'hFF, 8'd255, 1'b1, 1'b1, '{1'b1, 1'b0, 32'd1}},
      '{OP_QUERY,  8'h80, 8'd0,   1'b0, 1'b0, '{1'b0, 1'b0, 32'd0}},
      '{OP_INSERT, 8'h7F, 8'd7,   1'b0, 1'b0, '{1'b0, 1'b0, 32'd0}},
      '{OP_INSERT, 8'h00, 8'd3,   1'b1, 1'b1, '{1'b0, 1'b1, 32'd2}},
      '{OP_INSERT, 8'h80, 8'd0,   1'b0, 1'b0, '{1'b0, 1'b0, 32'd0}},
      '{OP_QUERY,  8'h7F, 8'd200, 1'b0, 1'b0, '{1'b0, 1'b0, 32'd0}},
      '{OP_QUERY,  8'h00, 8'd9,   1'b1, 1'b1, '{1'b1, 1'b0, 32'd2}},
      '{OP_QUERY,  8'h41, 8'd1,   1'b1, 1'b0, '{1'b0, 1'b0, 32'd0}},
      '{OP_INSERT, 8'h01, 8'd2,   1'b0, 1'b0, '{1'b0, 1'b0, 32'd0}},
      '{OP_INSERT, 8'hFE, 8'd2,   1'b1, 1'b0, '{1'b0, 1'b0, 32'd0}}
    };
  end

  initial begin
    logic [13:0] size_plan [7];
    logic [13:0] hash_plan [7];
    bfsk_in_t it;
    int n, sel, quota;
    bit long_done;

    size_plan = '{14'd8192, 14'd1, 14'd16383, 14'd0, 14'd8192, 14'd37, 14'd512};
    hash_plan = '{14'd7, 14'd1, 14'd9, 14'd0, 14'd15, 14'd3, 14'd9};
    for (int i = 0; i < STORE_SZ; i++) bit_mem[i] = 8'd0;
    restart_hashes();
    insert_total = 0;
    store_bytes = BYTES_RESET;
    num_hashes = HCOUNT_RESET;
    long_done = 1'b0;

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      it.opcode = directed_rows[i].op;
      it.key_byte = directed_rows[i].kb;
      it.key_length = directed_rows[i].kl;
      it.last_byte = directed_rows[i].last;
      send(it, directed_rows[i].typed, directed_rows[i].res);
    end

    for (int ph = 0; ph < 7; ph++) begin
      if (ph > 0) begin
        quiesce();
        write_reg(REG_BYTES, size_plan[ph]);
        write_reg(REG_HCOUNT, hash_plan[ph]);
        cfg_valid <= 1'b0;
      end
      if (ph == 6) idle_on = 1'b0;
      quota = bytes_sent + 45;
      while (bytes_sent < quota) begin
        sel = $urandom_range(0, 99);
        if (ph == 2 && !long_done) begin
          // A key past the nominal maximum length keeps hashing.
          long_done = 1'b1;
          for (int i = 0; i < KEY_MAX; i++) key_buf[i] = 8'($urandom);
          send_key(OP_INSERT, KEY_MAX, 8'($urandom));
        end else if (sel < 40 || bank_n == 0) begin
          n = $urandom_range(1, 12);
          for (int i = 0; i < n; i++) key_buf[i] = 8'($urandom);
          if (bank_n < BANK_MAX) begin
            for (int i = 0; i < n; i++) bank_bytes[bank_n][i] = key_buf[i];
            bank_len[bank_n] = n;
            bank_dlen[bank_n] = 8'(n);
            bank_n++;
          end
          send_key(OP_INSERT, n, 8'(n));
        end else if (sel < 75) begin
          sel = $urandom_range(0, bank_n - 1);
          n = bank_len[sel];
          for (int i = 0; i < n; i++) key_buf[i] = bank_bytes[sel][i];
          send_key(OP_QUERY, n, bank_dlen[sel]);
        end else begin
          // Unknown keys, often with a length field that disagrees.
          n = $urandom_range(1, 6);
          for (int i = 0; i < n; i++) key_buf[i] = 8'($urandom);
          send_key(logic'($urandom_range(0, 1)), n, 8'($urandom));
        end
      end
    end

    quiesce();
    $display("Sent %0d key bytes in %0d keys over 7 size and hash settings.",
             bytes_sent, keys_sent);
    $display("Checked %0d results, %0d of them query hits.", results_seen, found_hits);
    if (error_count == 0) begin
      $display("bloom_filter_string_keys_top_test: clean");
    end else begin
      $display("bloom_filter_string_keys_top_test: errors");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("bloom_filter_string_keys_top_test: errors");
    $finish;
  end

endmodule

`default_nettype wire

### files.f
hdl/bfsk_pkg.sv
hdl/bfsk_front.sv
hdl/bfsk_queue.sv
hdl/bfsk_back.sv
hdl/bloom_filter_string_keys_top.sv
hdl/bfsk_checker.sv
bench/bloom_filter_string_keys_top_test.sv
